### rtl/core/mcr_pkg.sv
// Shared types and constants of the midpoint circle rasterizer.
// No dependencies; imported by every module of the block.
package mcr_pkg;

   localparam int NUM_SLOTS     = 8;
   localparam int SLOT_BITS     = 3;
   localparam int FIELD_BITS    = 14;
   localparam int STEP_BITS     = 15;
   localparam int DIM_BITS      = 15;
   localparam int DEC_BITS      = 20;
   localparam int CRD_BITS      = 18;
   localparam int INK_PORT_BITS = 32;
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 80;
   localparam int RSP_USER_BITS = 2;

   localparam logic [DEC_BITS-1:0] DEC_INIT     = 20'd3;
   localparam logic [DEC_BITS-1:0] DEC_STEP_INC = 20'd6;
   localparam logic [DEC_BITS-1:0] DEC_DIAG_INC = 20'd10;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 15'd1024;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_DRAW = 2'd1,
      PHASE_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]                 valid;
      logic [NUM_SLOTS-1:0][FIELD_BITS-1:0] row;
      logic [NUM_SLOTS-1:0][FIELD_BITS-1:0] col_first;
      logic [NUM_SLOTS-1:0][FIELD_BITS-1:0] col_last;
   } cand_type;

endpackage

### rtl/core/mcr_paint.sv
// Candidate write generator: eight clipped pixels or four clipped spans for one x position.
// Depends on mcr_pkg.
module mcr_paint
   import mcr_pkg::*;
(
   input  logic [STEP_BITS-1:0]    step_x,
   input  logic [STEP_BITS-1:0]    step_y,
   input  logic signed [15:0]      center_x,
   input  logic signed [15:0]      center_y,
   input  logic                    fill_mode,
   input  logic [DIM_BITS-1:0]     width_eff,
   input  logic [DIM_BITS-1:0]     height_eff,
   output cand_type                cand
);

   logic signed [CRD_BITS-1:0] cx_s, cy_s, x_s, y_s, w_s, h_s, w_last_s;
   logic signed [CRD_BITS-1:0] cx_px, cx_mx, cx_py, cx_my, cy_px, cy_mx, cy_py, cy_my;
   logic signed [CRD_BITS-1:0] row_s [NUM_SLOTS];
   logic signed [CRD_BITS-1:0] c0_s  [NUM_SLOTS];
   logic signed [CRD_BITS-1:0] c1_s  [NUM_SLOTS];
   logic signed [CRD_BITS-1:0] c0_cl [NUM_SLOTS];
   logic signed [CRD_BITS-1:0] c1_cl [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]       en;

   always_comb begin
      cx_s     = CRD_BITS'(center_x);
      cy_s     = CRD_BITS'(center_y);
      x_s      = signed'({3'b000, step_x});
      y_s      = signed'({3'b000, step_y});
      w_s      = signed'({3'b000, width_eff});
      h_s      = signed'({3'b000, height_eff});
      w_last_s = w_s - 18'sd1;
      cx_px    = cx_s + x_s;
      cx_mx    = cx_s - x_s;
      cx_py    = cx_s + y_s;
      cx_my    = cx_s - y_s;
      cy_px    = cy_s + x_s;
      cy_mx    = cy_s - x_s;
      cy_py    = cy_s + y_s;
      cy_my    = cy_s - y_s;
   end

   always_comb begin
      if (fill_mode) begin
         en       = 8'b0000_1111;
         row_s[0] = cy_py;  c0_s[0] = cx_mx;  c1_s[0] = cx_px;
         row_s[1] = cy_my;  c0_s[1] = cx_mx;  c1_s[1] = cx_px;
         row_s[2] = cy_px;  c0_s[2] = cx_my;  c1_s[2] = cx_py;
         row_s[3] = cy_mx;  c0_s[3] = cx_my;  c1_s[3] = cx_py;
         row_s[4] = cy_my;  c0_s[4] = cx_px;  c1_s[4] = cx_px;
         row_s[5] = cy_py;  c0_s[5] = cx_px;  c1_s[5] = cx_px;
         row_s[6] = cy_my;  c0_s[6] = cx_mx;  c1_s[6] = cx_mx;
         row_s[7] = cy_py;  c0_s[7] = cx_mx;  c1_s[7] = cx_mx;
      end else begin
         en       = 8'b1111_1111;
         row_s[0] = cy_mx;  c0_s[0] = cx_py;  c1_s[0] = cx_py;
         row_s[1] = cy_px;  c0_s[1] = cx_py;  c1_s[1] = cx_py;
         row_s[2] = cy_mx;  c0_s[2] = cx_my;  c1_s[2] = cx_my;
         row_s[3] = cy_px;  c0_s[3] = cx_my;  c1_s[3] = cx_my;
         row_s[4] = cy_my;  c0_s[4] = cx_px;  c1_s[4] = cx_px;
         row_s[5] = cy_py;  c0_s[5] = cx_px;  c1_s[5] = cx_px;
         row_s[6] = cy_my;  c0_s[6] = cx_mx;  c1_s[6] = cx_mx;
         row_s[7] = cy_py;  c0_s[7] = cx_mx;  c1_s[7] = cx_mx;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         c0_cl[i] = (c0_s[i] < 18'sd0) ? 18'sd0 : c0_s[i];
         c1_cl[i] = (c1_s[i] > w_last_s) ? w_last_s : c1_s[i];
         cand.valid[i] = en[i] && (row_s[i] >= 18'sd0) && (row_s[i] < h_s)
                         && (c1_s[i] >= 18'sd0) && (c0_s[i] < w_s);
         cand.row[i]       = row_s[i][FIELD_BITS-1:0];
         cand.col_first[i] = c0_cl[i][FIELD_BITS-1:0];
         cand.col_last[i]  = c1_cl[i][FIELD_BITS-1:0];
      end
   end

endmodule

### rtl/core/mcr_burst.sv
// Result buffer: holds the surviving writes of one step and sends them one per transaction.
// Depends on mcr_pkg.
module mcr_burst
   import mcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  cand_type                 cand,
   input  logic                     step_done,
   input  logic [INK_PORT_BITS-1:0] ink,
   output logic                     can_load,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // fields from bit 0: row, col_first, col_last, ink_out, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // fields from bit 0: write_valid, drawing_done
   output logic [RSP_USER_BITS-1:0] rsp_tuser,
   output logic                     rsp_tlast
);

   logic [NUM_SLOTS-1:0]  mask_ff, mask_in, rest_mask;
   cand_type              ent_ff;
   logic [INK_PORT_BITS-1:0] ink_ff;
   logic                  wvalid_ff, done_ff;
   logic [SLOT_BITS-1:0]  sel;
   logic                  take, take_last;
   logic [FIELD_BITS-1:0] row_o, c0_o, c1_o;
   logic [INK_PORT_BITS-1:0] ink_o;

   always_comb begin
      sel = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      rest_mask  = mask_ff & (mask_ff - 1'b1);
      rsp_tvalid = |mask_ff;
      rsp_tlast  = (rest_mask == '0);
      take       = rsp_tvalid && rsp_tready;
      take_last  = take && rsp_tlast;
      can_load   = !rsp_tvalid || take_last;
      if (load) begin
         mask_in = (|cand.valid) ? cand.valid : NUM_SLOTS'(1);
      end else if (take) begin
         mask_in = rest_mask;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff    <= cand;
         ink_ff    <= ink;
         wvalid_ff <= |cand.valid;
         done_ff   <= step_done;
      end
   end

   always_comb begin
      row_o = wvalid_ff ? ent_ff.row[sel]       : '0;
      c0_o  = wvalid_ff ? ent_ff.col_first[sel] : '0;
      c1_o  = wvalid_ff ? ent_ff.col_last[sel]  : '0;
      ink_o = wvalid_ff ? ink_ff                : '0;
      rsp_tdata = {6'b000000, ink_o, c1_o, c0_o, row_o};
      rsp_tuser = {done_ff, wvalid_ff};
   end

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_tvalid || take_last))
      else $error("step loaded while result buffer still busy");

   a_invalid_single : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !wvalid_ff) |-> $onehot(mask_ff))
      else $error("invalid result is not a single transaction");

   a_burst_continues : assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_tlast) |=> rsp_tvalid)
      else $error("burst ended before its last transaction");

endmodule

### rtl/core/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer. An accepted transaction is registered; a step waits there until
// the result buffer can load, and its first result then passes the buffer's mask register. A
// step sends 1 to 8 results, one per cycle while rsp_tready is high; a start retires without
// waiting and overlaps a draining step. Synchronous active-high reset clears the phase to idle,
// the walk state to zero and both image registers to 1024. Depends on mcr_pkg.
module midpoint_circle_rasterizer_unit
   import mcr_pkg::*;
#(
   parameter int INK_BYTES  = 4,
   parameter int COORD_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [DIM_BITS-1:0]      csr_wr_data,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // fields from bit 0: center_x, center_y, circle_radius, fill_mode, ink_value, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // fields from bit 0: req_type
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // fields from bit 0: row, col_first, col_last, ink_out, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // fields from bit 0: write_valid, drawing_done
   output logic [RSP_USER_BITS-1:0] rsp_tuser,
   output logic                     rsp_tlast
);

   localparam int INK_W = (INK_BYTES * 8 > INK_PORT_BITS) ? INK_PORT_BITS : INK_BYTES * 8;
   localparam logic [16:0] DIM_LIMIT = 17'(1) << COORD_BITS;

   logic [DIM_BITS-1:0] width_ff, height_ff, width_eff, height_eff;
   logic [16:0]         width_lim, height_lim;

   logic                in_valid_ff, in_type_ff, in_fill_ff;
   logic signed [15:0]  in_cx_ff, in_cy_ff;
   logic [13:0]         in_radius_ff;
   logic [INK_W-1:0]    in_ink_ff;

   logic [STEP_BITS-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [DEC_BITS-1:0]  decision_ff, decision_in;
   logic signed [15:0]   latched_cx_ff, latched_cy_ff;
   logic                 latched_fill_ff;
   logic [INK_W-1:0]     latched_ink_ff;
   phase_type            phase_ff, phase_in;

   logic process, do_start, do_step, draw_active, can_load, step_done, x_lt_y, off_image;
   logic [DEC_BITS-1:0]   x20, y20;
   logic [STEP_BITS-1:0]  x_next, y_next;
   logic signed [CRD_BITS-1:0] cx_s, cy_s, r_s, w_s, h_s;
   cand_type              cand;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_lim  = ({2'b00, width_ff} < DIM_LIMIT) ? {2'b00, width_ff} : DIM_LIMIT;
      height_lim = ({2'b00, height_ff} < DIM_LIMIT) ? {2'b00, height_ff} : DIM_LIMIT;
      width_eff  = width_lim[DIM_BITS-1:0];
      height_eff = height_lim[DIM_BITS-1:0];
   end

   always_comb begin
      process    = in_valid_ff && ((in_type_ff == REQ_START) || can_load);
      do_start   = process && (in_type_ff == REQ_START);
      do_step    = process && (in_type_ff == REQ_STEP);
      req_tready = !in_valid_ff || process;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff   <= req_tuser;
         in_cx_ff     <= req_tdata[15:0];
         in_cy_ff     <= req_tdata[31:16];
         in_radius_ff <= req_tdata[45:32];
         in_fill_ff   <= req_tdata[46];
         in_ink_ff    <= req_tdata[47 +: INK_W];
      end
   end

   always_comb begin
      cx_s      = CRD_BITS'(in_cx_ff);
      cy_s      = CRD_BITS'(in_cy_ff);
      r_s       = signed'({4'b0000, in_radius_ff});
      w_s       = signed'({3'b000, width_ff});
      h_s       = signed'({3'b000, height_ff});
      off_image = (cx_s + r_s < 18'sd0) || (cx_s - r_s >= w_s)
                  || (cy_s + r_s < 18'sd0) || (cy_s - r_s >= h_s);
   end

   always_comb begin
      x20    = DEC_BITS'(step_x_ff);
      y20    = DEC_BITS'(step_y_ff);
      x_lt_y = step_x_ff < step_y_ff;
      x_next = step_x_ff + 1'b1;
      y_next = decision_ff[DEC_BITS-1] ? step_y_ff : step_y_ff - 1'b1;
      step_done = !draw_active || !x_lt_y || (x_next > y_next);
   end

   always_comb begin
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      decision_in = decision_ff;
      if (do_start) begin
         step_x_in   = '0;
         step_y_in   = STEP_BITS'(in_radius_ff);
         decision_in = DEC_INIT - {5'b00000, in_radius_ff, 1'b0};
      end else if (do_step && draw_active && x_lt_y) begin
         step_x_in = x_next;
         step_y_in = y_next;
         if (decision_ff[DEC_BITS-1]) begin
            decision_in = decision_ff + (x20 << 2) + DEC_STEP_INC;
         end else begin
            decision_in = decision_ff + ((x20 - y20) << 2) + DEC_DIAG_INC;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (do_start) begin
         phase_in = off_image ? PHASE_DONE : PHASE_DRAW;
      end else if (do_step && draw_active && step_done) begin
         phase_in = PHASE_DONE;
      end
   end

   always_comb begin
      case (phase_ff)
         PHASE_DRAW: draw_active = 1'b1;
         default:    draw_active = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         step_x_ff       <= '0;
         step_y_ff       <= '0;
         decision_ff     <= '0;
         latched_cx_ff   <= '0;
         latched_cy_ff   <= '0;
         latched_fill_ff <= 1'b0;
         latched_ink_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         if (do_start) begin
            latched_cx_ff   <= in_cx_ff;
            latched_cy_ff   <= in_cy_ff;
            latched_fill_ff <= in_fill_ff;
            latched_ink_ff  <= in_ink_ff;
         end
      end
   end

   mcr_paint u_paint (
      .step_x     (step_x_ff),
      .step_y     (step_y_ff),
      .center_x   (latched_cx_ff),
      .center_y   (latched_cy_ff),
      .fill_mode  (latched_fill_ff),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .cand       (cand)
   );

   mcr_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (do_step),
      .cand       (draw_active ? cand : '0),
      .step_done  (step_done),
      .ink        (INK_PORT_BITS'(latched_ink_ff)),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
